// File: design/nps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_pkg
// Shared widths and types for the priority scheduler and its ready queue.
// ----------------------------------------------------------------------------
package nps_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 16;
   localparam int PRIO_BITS   = 16;
   localparam int RUN_BITS    = 16;
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [ID_BITS-1:0]   id;
      logic [RUN_BITS-1:0]  run;
      logic [PRIO_BITS-1:0] prio;
   } entry_type;

   // registered contents of a cell plus its compare against the arrival
   typedef struct packed {
      logic      occ;
      logic      le;
      entry_type entry;
   } cell_stat_type;

   // contents of a cell once the arrival has been inserted
   typedef struct packed {
      logic      occ;
      entry_type entry;
   } cell_post_type;

   // broadcast to every cell
   typedef struct packed {
      logic      step;
      logic      ins;
      logic      pop;
      entry_type entry;
   } queue_ctl_type;

   typedef struct packed {
      logic                  full;
      logic                  head_occ;
      entry_type             head;
      logic [COUNT_BITS-1:0] count_in;
   } queue_stat_type;

endpackage

// File: design/nps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_cell
// One slot of the sorted ready queue. Takes from its left neighbor on an
// insert below it, from its right neighbor on a pop.
// ----------------------------------------------------------------------------
module nps_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  nps_pkg::queue_ctl_type ctl,
   input  nps_pkg::cell_stat_type left_stat,
   input  nps_pkg::cell_post_type right_post,
   output nps_pkg::cell_stat_type stat,
   output nps_pkg::cell_post_type post
);
   import nps_pkg::*;

   logic      occ_ff, occ_in;
   entry_type entry_ff, entry_in;
   logic      le;

   // equal priorities stay ahead of the new word
   assign le = occ_ff && (entry_ff.prio <= ctl.entry.prio);

   assign stat.occ   = occ_ff;
   assign stat.le    = le;
   assign stat.entry = entry_ff;

   always_comb begin
      post.occ   = occ_ff;
      post.entry = entry_ff;
      if (ctl.ins && !le) begin
         if (left_stat.le) begin
            post.occ   = 1'b1;
            post.entry = ctl.entry;
         end else begin
            post.occ   = left_stat.occ;
            post.entry = left_stat.entry;
         end
      end
   end

   always_comb begin
      if (ctl.pop) begin
         occ_in   = right_post.occ;
         entry_in = right_post.entry;
      end else begin
         occ_in   = post.occ;
         entry_in = post.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else if (ctl.step) begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         entry_ff <= entry_in;
      end
   end

endmodule

// File: design/nps_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_queue
// Ready queue as a row of cells, sorted by ascending priority, FIFO among
// equals. Insert and pop both complete in one step.
// ----------------------------------------------------------------------------
module nps_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  nps_pkg::queue_ctl_type  ctl,
   output nps_pkg::queue_stat_type qstat
);
   import nps_pkg::*;

   cell_stat_type         stat_w [QUEUE_DEPTH];
   cell_post_type         post_w [QUEUE_DEPTH];
   logic [COUNT_BITS-1:0] count_ff, count_in;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_stat_type left_s;
      cell_post_type right_p;

      if (i == 0) begin : g_first
         // head slot: an arrival that beats everything lands here
         assign left_s = '{occ: 1'b0, le: 1'b1, entry: '0};
      end else begin : g_mid
         assign left_s = stat_w[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_p = '{occ: 1'b0, entry: '0};
      end else begin : g_body
         assign right_p = post_w[i+1];
      end

      nps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .left_stat  (left_s),
         .right_post (right_p),
         .stat       (stat_w[i]),
         .post       (post_w[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.ins) count_in = count_in + COUNT_BITS'(1);
      if (ctl.pop) count_in = count_in - COUNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctl.step) begin
         count_ff <= count_in;
      end
   end

   assign qstat.full     = stat_w[QUEUE_DEPTH-1].occ;
   assign qstat.head_occ = post_w[0].occ;
   assign qstat.head     = post_w[0].entry;
   assign qstat.count_in = count_in;

endmodule

// File: design/nonpreemptive_priority_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler
// Non-preemptive priority scheduler: sorted ready queue plus one CPU slot.
// ----------------------------------------------------------------------------
// Each word on the req_ channel is one scheduler tick, optionally carrying an
// arriving job (id, run time, priority). The job goes into a 16-entry ready
// queue built as a row of cells, sorted by priority with ties kept in arrival
// order; a full queue drops the arrival and flags it. The running job then
// counts down, a job reaching zero is reported done, and an idle CPU takes
// the queue head in the same tick. A zero run time counts as one tick.
// Every tick yields exactly one rsp_ word, in the cycle after acceptance.
// Throughput is one tick per clock while req_stall is low: every cell shifts
// together and the CPU countdown is a single decrement.
// rsp_ words sit in an output register; while rsp_stall is high and that
// register is full, req_stall is raised and no tick is taken.
// Reset (synchronous, active high) empties the queue, idles the CPU and
// marks the output register empty.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_arrival_valid,
   input  logic [15:0] req_arrival_id,
   input  logic [15:0] req_arrival_run_time,
   input  logic [15:0] req_arrival_priority,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_done_valid,
   output logic [15:0] rsp_done_id,
   output logic        rsp_cpu_busy,
   output logic [15:0] rsp_running_id,
   output logic [4:0]  rsp_queue_count,
   output logic        rsp_arrival_dropped
);
   import nps_pkg::*;

   queue_ctl_type        ctl;
   queue_stat_type       qstat;
   logic                 step;

   logic                 busy_ff, busy_in;
   logic [RUN_BITS-1:0]  remain_ff, remain_in;
   logic [ID_BITS-1:0]   cur_id_ff, cur_id_in;
   logic                 done;
   logic                 busy_mid;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_done_valid_ff;
   logic [15:0]          rsp_done_id_ff;
   logic                 rsp_cpu_busy_ff;
   logic [15:0]          rsp_running_id_ff;
   logic [4:0]           rsp_queue_count_ff;
   logic                 rsp_arrival_dropped_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign step      = req_valid && !req_stall;

   always_comb begin
      ctl.step       = step;
      ctl.ins        = req_arrival_valid && !qstat.full;
      ctl.entry.id   = req_arrival_id[ID_BITS-1:0];
      ctl.entry.run  = req_arrival_run_time[RUN_BITS-1:0];
      ctl.entry.prio = req_arrival_priority[PRIO_BITS-1:0];

      // remaining time is never zero while busy
      done     = busy_ff && (remain_ff <= RUN_BITS'(1));
      busy_mid = busy_ff && !done;
      ctl.pop  = !busy_mid && qstat.head_occ;

      busy_in   = busy_mid;
      remain_in = busy_ff ? remain_ff - RUN_BITS'(1) : remain_ff;
      cur_id_in = cur_id_ff;
      if (ctl.pop) begin
         busy_in   = 1'b1;
         cur_id_in = qstat.head.id;
         remain_in = (qstat.head.run == '0) ? RUN_BITS'(1) : qstat.head.run;
      end

      rsp_valid_in = step ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   nps_queue u_queue (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .qstat (qstat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         remain_ff    <= '0;
         cur_id_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            busy_ff   <= busy_in;
            remain_ff <= remain_in;
            cur_id_ff <= cur_id_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_done_valid_ff      <= done;
         rsp_done_id_ff         <= done ? 16'(cur_id_ff) : '0;
         rsp_cpu_busy_ff        <= busy_in;
         rsp_running_id_ff      <= busy_in ? 16'(cur_id_in) : '0;
         rsp_queue_count_ff     <= 5'(qstat.count_in);
         rsp_arrival_dropped_ff <= req_arrival_valid && qstat.full;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_done_valid      = rsp_done_valid_ff;
   assign rsp_done_id         = rsp_done_id_ff;
   assign rsp_cpu_busy        = rsp_cpu_busy_ff;
   assign rsp_running_id      = rsp_running_id_ff;
   assign rsp_queue_count     = rsp_queue_count_ff;
   assign rsp_arrival_dropped = rsp_arrival_dropped_ff;

endmodule
